[hw/rtl/bpsr_pkg.sv]
// ---------------------------------------------------------------------------
// bpsr_pkg: shared types and constants
// Box record, field widths and sequencer states for the box pair relation core
// ---------------------------------------------------------------------------
package bpsr_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam int ID_W          = 16;
  localparam int COORD_W       = 24;
  localparam int UPM_W         = 20;
  localparam int SCORE_W       = 13;
  localparam int QUOT_W        = 12;
  localparam int ROOT_W        = 25;
  localparam int THR_W         = UPM_W + 2;
  localparam int GEO_W         = 32;

  localparam logic [UPM_W-1:0] UPM_RESET = 20'd4096;

  // full score, one in Q1.12
  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(4096);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
  } box_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_S,
    ST_LD_R,
    ST_SEP,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_U,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

endpackage

[hw/rtl/bpsr_sqrt.sv]
// ---------------------------------------------------------------------------
// bpsr_sqrt: bit-serial integer square root
// Shifts the radicand in two bits a cycle and settles one root bit a cycle
// ---------------------------------------------------------------------------
module bpsr_sqrt #(
  parameter int W = bpsr_pkg::ROOT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] rad,
  output logic [W-1:0]   root,
  output logic           done
);

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] rad_r, rad_nxt;
  logic [W+1:0]   rem_r, rem_nxt;
  logic [W-1:0]   root_r, root_nxt;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W+1:0]   rem_sh;
  logic [W+1:0]   trial;
  logic           ge;

  // one root digit per step
  always_comb begin
    rem_sh   = {rem_r[W-1:0], rad_r[2*W-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[W-2:0], ge};
    rad_nxt  = {rad_r[2*W-3:0], 2'b00};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

[hw/rtl/bpsr_div.sv]
// ---------------------------------------------------------------------------
// bpsr_div: bit-serial fraction divider
// Gives floor(num * 2^QW / den) for num below den, one quotient bit a cycle
// ---------------------------------------------------------------------------
module bpsr_div #(
  parameter int NW = bpsr_pkg::THR_W,
  parameter int QW = bpsr_pkg::QUOT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] den_r;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW:0]   rem_sh;
  logic          ge;

  // restoring step, remainder stays below the divisor
  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? NW'(rem_sh - {1'b0, den_r}) : rem_sh[NW-1:0];
    q_nxt   = {q_r[QW-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

[hw/rtl/box_pair_spatial_relation_core.sv]
// ---------------------------------------------------------------------------
// box_pair_spatial_relation_core: box table with pairwise relation queries
// Stores boxes by slot and reports near, next-to, on, left and right relations
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A write item
//   (req_type 0) stores the box in its slot at that edge and causes no
//   result; busy stays low, so writes may follow every cycle.
//   A query item (req_type 1) raises busy and gives one result, marked by
//   out_valid for a single cycle; the receiver cannot stall it.
//   The query runs two table reads, the separations, three products on one
//   shared multiplier, a bit-serial square root, then two bit-serial
//   dividers working side by side. busy falls as out_valid rises.
//   An unwritten slot or equal ids end the query after the separations;
//   out_valid then rises and busy falls in the same way.
//   cfg_valid with cfg_ready writes the scale register; cfg_ready is always
//   high. The register must be written only while the block is idle; the
//   block itself does not enforce this.
//   Synchronous reset clears the written-slot flags, the sequencer and sets
//   the scale register to 4096; the box table itself is not cleared.
// ---------------------------------------------------------------------------
module box_pair_spatial_relation_core #(
  parameter int MAX_BOXES = bpsr_pkg::MAX_BOXES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_req_type,
  input  logic [3:0]                            in_slot,
  input  logic [3:0]                            in_ref_slot,
  input  logic [bpsr_pkg::ID_W-1:0]             in_obj_id,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_min_x,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_min_y,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_min_z,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_max_x,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_max_y,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_max_z,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_center_x,
  input  logic signed [bpsr_pkg::COORD_W-1:0]   in_center_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpsr_pkg::UPM_W-1:0]            cfg_data,
  output logic                                  out_valid,
  output logic                                  out_slot_error,
  output logic [bpsr_pkg::ID_W-1:0]             out_subject_id,
  output logic [bpsr_pkg::ID_W-1:0]             out_reference_id,
  output logic                                  out_is_near,
  output logic [bpsr_pkg::SCORE_W-1:0]          out_near_score,
  output logic                                  out_is_next_to,
  output logic [bpsr_pkg::SCORE_W-1:0]          out_next_to_score,
  output logic                                  out_is_on,
  output logic                                  out_is_left_of,
  output logic                                  out_is_right_of
);

  localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW   = bpsr_pkg::COORD_W;
  localparam int UW   = bpsr_pkg::UPM_W;
  localparam int RW   = bpsr_pkg::ROOT_W;
  localparam int TW   = bpsr_pkg::THR_W;
  localparam int QW   = bpsr_pkg::QUOT_W;
  localparam int GW   = bpsr_pkg::GEO_W;
  localparam int SW   = 9;
  localparam int SUMW = 2 * CW + 1;
  localparam int SCORE_W_L = bpsr_pkg::SCORE_W;

  bpsr_pkg::state_t state_r, state_nxt;

  bpsr_pkg::box_t mem [MAX_BOXES];
  bpsr_pkg::box_t rd_q;
  bpsr_pkg::box_t sub_r, ref_r;
  bpsr_pkg::box_t wr_box;

  logic [MAX_BOXES-1:0] written_r;
  logic [UW-1:0]        upm_r;
  logic [AW-1:0]        s_addr_r;
  logic                 err_r;

  logic [SW-1:0] slot_ext, ref_ext;
  logic [AW-1:0] slot_addr, ref_addr, rd_addr;
  logic          accept, do_write, do_query;
  logic          slot_ok, ref_ok;

  // ---- channel control
  assign accept    = start && !busy;
  assign do_write  = accept && (in_req_type == bpsr_pkg::REQ_WRITE);
  assign do_query  = accept && (in_req_type == bpsr_pkg::REQ_QUERY);
  assign busy      = (state_r != bpsr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // slot range and written checks
  assign slot_ext  = {{(SW-4){1'b0}}, in_slot};
  assign ref_ext   = {{(SW-4){1'b0}}, in_ref_slot};
  assign slot_addr = slot_ext[AW-1:0];
  assign ref_addr  = ref_ext[AW-1:0];
  assign slot_ok   = (slot_ext < SW'(MAX_BOXES)) && written_r[slot_addr];
  assign ref_ok    = (ref_ext < SW'(MAX_BOXES)) && written_r[ref_addr];

  assign wr_box = '{id: in_obj_id, min_x: in_min_x, min_y: in_min_y, min_z: in_min_z,
                    max_x: in_max_x, max_y: in_max_y, max_z: in_max_z,
                    center_x: in_center_x, center_y: in_center_y};

  // read subject on accept, reference in the next cycle
  assign rd_addr = (state_r == bpsr_pkg::ST_IDLE) ? slot_addr : s_addr_r;

  // ---- box table
  always_ff @(posedge clk) begin
    if (do_write && (slot_ext < SW'(MAX_BOXES))) begin
      mem[slot_addr] <= wr_box;
    end
    rd_q <= mem[rd_addr];
  end

  // written flags and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      upm_r     <= bpsr_pkg::UPM_RESET;
    end else begin
      if (do_write && (slot_ext < SW'(MAX_BOXES))) begin
        written_r[slot_addr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        upm_r <= cfg_data;
      end
    end
  end

  // ---- datapath signals
  logic [UW-1:0]     upm_eff;
  logic signed [CW:0] sx_a, sx_b, sy_a, sy_b;
  logic [CW-1:0]     dx_r, dy_r;
  logic [CW-1:0]     dx_c, dy_c;
  logic [CW-1:0]     mul_a, mul_b;
  logic [2*CW-1:0]   prod;
  logic [2*CW-1:0]   sqx_r;
  logic [SUMW-1:0]   sum_r;
  logic [2*UW-1:0]   upm2_r;
  logic              near_r, next_r, on_r, left_r, right_r;
  logic              near_c, next_c;
  logic [SUMW+3:0]   sum16;
  logic [2*UW+3:0]   upm2x9;
  logic              ids_eq;

  assign upm_eff = (upm_r == '0) ? UW'(1) : upm_r;
  assign ids_eq  = (sub_r.id == ref_r.id);

  // planar separations, clamped at zero
  always_comb begin
    sx_a = (CW+1)'(ref_r.min_x) - (CW+1)'(sub_r.max_x);
    sx_b = (CW+1)'(sub_r.min_x) - (CW+1)'(ref_r.max_x);
    sy_a = (CW+1)'(ref_r.min_y) - (CW+1)'(sub_r.max_y);
    sy_b = (CW+1)'(sub_r.min_y) - (CW+1)'(ref_r.max_y);
    dx_c = '0;
    if (sx_a > 0) dx_c = sx_a[CW-1:0];
    if (sx_b > 0 && sx_b > sx_a) dx_c = sx_b[CW-1:0];
    dy_c = '0;
    if (sy_a > 0) dy_c = sy_a[CW-1:0];
    if (sy_b > 0 && sy_b > sy_a) dy_c = sy_b[CW-1:0];
  end

  // on test, scaled by 25; left and right tests use the raw coordinates
  logic signed [GW-1:0] wx, wy, inx, iny, upm_s, cx, cy;
  logic signed [GW-1:0] bx0, bx3, by1, by4;
  logic                 hor_c, vert_c;

  function automatic logic signed [GW-1:0] times25(input logic signed [CW-1:0] v);
    logic signed [GW-1:0] e;
    e = GW'(v);
    return (e <<< 4) + (e <<< 3) + e;
  endfunction

  always_comb begin
    upm_s  = GW'(upm_eff);
    wx     = (GW'(ref_r.max_x) - GW'(ref_r.min_x)) * 5;
    wy     = (GW'(ref_r.max_y) - GW'(ref_r.min_y)) * 5;
    inx    = (upm_s < wx) ? upm_s : wx;
    iny    = (upm_s < wy) ? upm_s : wy;
    cx     = times25(sub_r.center_x);
    cy     = times25(sub_r.center_y);
    bx0    = times25(ref_r.min_x);
    bx3    = times25(ref_r.max_x);
    by1    = times25(ref_r.min_y);
    by4    = times25(ref_r.max_y);
    hor_c  = (cx >= bx0 + inx) && (cx <= bx3 - inx) &&
             (cy >= by1 + iny) && (cy <= by4 - iny);
    vert_c = (sub_r.max_z >= ref_r.min_z) && (sub_r.min_z <= ref_r.max_z);
  end

  // shared multiplier
  always_comb begin
    unique case (state_r)
      bpsr_pkg::ST_MUL_X: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      bpsr_pkg::ST_MUL_Y: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      default: begin
        mul_a = CW'(upm_eff);
        mul_b = CW'(upm_eff);
      end
    endcase
    prod = mul_a * mul_b;
  end

  // squared-gap threshold compares
  always_comb begin
    sum16  = {sum_r, 4'b0000};
    upm2x9 = (2*UW+4)'({upm2_r, 3'b000}) + (2*UW+4)'(upm2_r);
    near_c = (sum16 < (SUMW+4)'(upm2x9));
    next_c = (sum16 < (SUMW+4)'({upm2_r, 4'b0000}) >> 4) ;
  end

  // ---- serial units
  logic [RW-1:0] root;
  logic          sq_done, div_done3, div_done1;
  logic [QW-1:0] q3, q1;
  logic [TW-1:0] thr3, thr1, num3, num1;
  logic [RW+1:0] g4;
  logic          gap_zero;

  assign thr3 = TW'({upm_eff, 1'b0}) + TW'(upm_eff);
  assign thr1 = TW'(upm_eff);
  assign g4   = {root, 2'b00};
  assign num3 = (g4 >= (RW+2)'(thr3)) ? '0 : TW'((RW+2)'(thr3) - g4);
  assign num1 = (g4 >= (RW+2)'(thr1)) ? '0 : TW'((RW+2)'(thr1) - g4);

  // zero gap gives a full score, one bit above the quotient width
  assign gap_zero = (root == '0);

  bpsr_sqrt #(.W(RW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == bpsr_pkg::ST_SQ_GO),
    .rad   ({1'b0, sum_r}),
    .root  (root),
    .done  (sq_done)
  );

  bpsr_div #(.NW(TW), .QW(QW)) u_div_near (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == bpsr_pkg::ST_DIV_GO),
    .num   (num3),
    .den   (thr3),
    .quot  (q3),
    .done  (div_done3)
  );

  bpsr_div #(.NW(TW), .QW(QW)) u_div_next (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == bpsr_pkg::ST_DIV_GO),
    .num   (num1),
    .den   (thr1),
    .quot  (q1),
    .done  (div_done1)
  );

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpsr_pkg::ST_IDLE:     if (do_query) state_nxt = bpsr_pkg::ST_LD_S;
      bpsr_pkg::ST_LD_S:     state_nxt = bpsr_pkg::ST_LD_R;
      bpsr_pkg::ST_LD_R: begin
        state_nxt = bpsr_pkg::ST_SEP;
      end
      bpsr_pkg::ST_SEP: begin
        if (err_r || ids_eq) state_nxt = bpsr_pkg::ST_IDLE;
        else                 state_nxt = bpsr_pkg::ST_MUL_X;
      end
      bpsr_pkg::ST_MUL_X:    state_nxt = bpsr_pkg::ST_MUL_Y;
      bpsr_pkg::ST_MUL_Y:    state_nxt = bpsr_pkg::ST_MUL_U;
      bpsr_pkg::ST_MUL_U:    state_nxt = bpsr_pkg::ST_SQ_GO;
      bpsr_pkg::ST_SQ_GO:    state_nxt = bpsr_pkg::ST_SQ_WAIT;
      bpsr_pkg::ST_SQ_WAIT:  if (sq_done) state_nxt = bpsr_pkg::ST_DIV_GO;
      bpsr_pkg::ST_DIV_GO:   state_nxt = bpsr_pkg::ST_DIV_WAIT;
      bpsr_pkg::ST_DIV_WAIT: if (div_done3) state_nxt = bpsr_pkg::ST_IDLE;
      default:               state_nxt = bpsr_pkg::ST_IDLE;
    endcase
  end

  // query datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      bpsr_pkg::ST_IDLE: begin
        s_addr_r <= ref_addr;
        err_r    <= !(slot_ok && ref_ok);
      end
      bpsr_pkg::ST_LD_S: sub_r <= rd_q;
      bpsr_pkg::ST_LD_R: ref_r <= rd_q;
      bpsr_pkg::ST_SEP: begin
        dx_r    <= dx_c;
        dy_r    <= dy_c;
        on_r    <= hor_c && vert_c;
        left_r  <= (sub_r.max_x < ref_r.min_x);
        right_r <= (sub_r.min_x > ref_r.max_x);
      end
      bpsr_pkg::ST_MUL_X: sqx_r  <= prod;
      bpsr_pkg::ST_MUL_Y: sum_r  <= SUMW'(sqx_r) + SUMW'(prod);
      bpsr_pkg::ST_MUL_U: upm2_r <= prod[2*UW-1:0];
      bpsr_pkg::ST_SQ_GO: begin
        near_r <= near_c;
        next_r <= next_c;
      end
      default: ;
    endcase
  end

  // ---- result register
  logic                     ov_r;
  logic                     o_err_r, o_near_r, o_next_r, o_on_r, o_left_r, o_right_r;
  logic [bpsr_pkg::ID_W-1:0] o_sid_r, o_rid_r;
  logic [SCORE_W_L-1:0]     o_ns_r, o_ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ((state_r == bpsr_pkg::ST_SEP) && (err_r || ids_eq)) ||
              ((state_r == bpsr_pkg::ST_DIV_WAIT) && div_done3);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bpsr_pkg::ST_SEP) begin
      o_err_r   <= err_r;
      o_sid_r   <= err_r ? '0 : sub_r.id;
      o_rid_r   <= err_r ? '0 : ref_r.id;
      o_near_r  <= 1'b0;
      o_next_r  <= 1'b0;
      o_ns_r    <= '0;
      o_ts_r    <= '0;
      o_on_r    <= 1'b0;
      o_left_r  <= 1'b0;
      o_right_r <= 1'b0;
    end else if ((state_r == bpsr_pkg::ST_DIV_WAIT) && div_done3) begin
      o_near_r  <= near_r;
      o_next_r  <= next_r;
      o_ns_r    <= near_r ? (gap_zero ? bpsr_pkg::SCORE_ONE : SCORE_W_L'(q3)) : '0;
      o_ts_r    <= (next_r && div_done1) ?
                   (gap_zero ? bpsr_pkg::SCORE_ONE : SCORE_W_L'(q1)) : '0;
      o_on_r    <= on_r;
      o_left_r  <= left_r;
      o_right_r <= right_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_slot_error    = o_err_r;
  assign out_subject_id    = o_sid_r;
  assign out_reference_id  = o_rid_r;
  assign out_is_near       = o_near_r;
  assign out_near_score    = o_ns_r;
  assign out_is_next_to    = o_next_r;
  assign out_next_to_score = o_ts_r;
  assign out_is_on         = o_on_r;
  assign out_is_left_of    = o_left_r;
  assign out_is_right_of   = o_right_r;

  // ---- checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result given while still busy");

  a_next_implies_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_next_to |-> out_is_near) else $error("next-to without near");

  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot_error |-> !out_is_near && !out_is_on && out_subject_id == '0)
    else $error("slot error result carries relation data");

  a_near_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_near |-> out_near_score == '0) else $error("score without flag");

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: box pair spatial relation core
// Writes boxes into the table and queries slot pairs. Each query's result is
// predicted in the bench and checked against the strobed result, field by
// field. The scale register is changed between phases while the core is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT      = bpsr_pkg::MAX_BOXES_DEF;
  localparam int WD_LIMIT   = 3000;
  localparam int SETTLE_CYC = 60;
  localparam int IDW        = bpsr_pkg::ID_W;
  localparam int UPW        = bpsr_pkg::UPM_W;
  localparam int CRD_W      = bpsr_pkg::COORD_W;
  localparam int BOX_BITS   = $bits(bpsr_pkg::box_t);

  typedef struct {
    logic                          slot_error;
    logic [bpsr_pkg::ID_W-1:0]     subject_id;
    logic [bpsr_pkg::ID_W-1:0]     reference_id;
    logic                          is_near;
    logic [bpsr_pkg::SCORE_W-1:0]  near_score;
    logic                          is_next_to;
    logic [bpsr_pkg::SCORE_W-1:0]  next_to_score;
    logic                          is_on;
    logic                          is_left_of;
    logic                          is_right_of;
  } relation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = bpsr_pkg::REQ_WRITE;
  logic [3:0] in_slot = '0;
  logic [3:0] in_ref_slot = '0;
  logic [bpsr_pkg::ID_W-1:0] in_obj_id = '0;
  logic signed [bpsr_pkg::COORD_W-1:0] in_min_x = '0, in_min_y = '0, in_min_z = '0;
  logic signed [bpsr_pkg::COORD_W-1:0] in_max_x = '0, in_max_y = '0, in_max_z = '0;
  logic signed [bpsr_pkg::COORD_W-1:0] in_center_x = '0, in_center_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpsr_pkg::UPM_W-1:0] cfg_data = '0;
  logic out_valid, out_slot_error, out_is_near, out_is_next_to;
  logic out_is_on, out_is_left_of, out_is_right_of;
  logic [bpsr_pkg::ID_W-1:0] out_subject_id, out_reference_id;
  logic [bpsr_pkg::SCORE_W-1:0] out_near_score, out_next_to_score;

  // bench copy of the block state
  bpsr_pkg::box_t             box_tab [NSLOT];
  bit                         slot_used [NSLOT];
  logic [bpsr_pkg::UPM_W-1:0] upm_model = bpsr_pkg::UPM_RESET;

  relation_t pending_relations[$];
  int        errors = 0;
  int        idle_pct = 0;
  int        stall_cnt = 0;

  always #4 clk = ~clk;

  box_pair_spatial_relation_core u_dut (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_slot, .in_ref_slot, .in_obj_id,
    .in_min_x, .in_min_y, .in_min_z, .in_max_x, .in_max_y, .in_max_z,
    .in_center_x, .in_center_y,
    .cfg_valid, .cfg_ready, .cfg_data,
    .out_valid, .out_slot_error, .out_subject_id, .out_reference_id,
    .out_is_near, .out_near_score, .out_is_next_to, .out_next_to_score,
    .out_is_on, .out_is_left_of, .out_is_right_of
  );

  // ---------------- prediction ----------------

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint axis_gap(longint smin, longint smax, longint rmin, longint rmax);
    longint d;
    d = 0;
    if (rmin - smax > d) d = rmin - smax;
    if (smin - rmax > d) d = smin - rmax;
    return d;
  endfunction

  function automatic logic [bpsr_pkg::SCORE_W-1:0] closeness(longint unsigned k,
                                                             longint unsigned upm,
                                                             longint unsigned g);
    longint unsigned thr, g4, s;
    thr = k * upm;
    g4 = 4 * g;
    if (g4 >= thr) return '0;
    s = ((thr - g4) * 4096) / thr;
    if (s > 4096) s = 4096;
    return s[bpsr_pkg::SCORE_W-1:0];
  endfunction

  function automatic relation_t predict_relation(int s, int r);
    relation_t res;
    bpsr_pkg::box_t a, b;
    longint dx, dy, wx, wy, inx, iny, cx, cy;
    longint unsigned sum, upm, g;
    bit hor, vert;
    res = '{default: '0};
    if (!slot_used[s] || !slot_used[r]) begin
      res.slot_error = 1'b1;
      return res;
    end
    a = box_tab[s];
    b = box_tab[r];
    res.subject_id = a.id;
    res.reference_id = b.id;
    if (a.id == b.id) return res;
    upm = (upm_model == 0) ? 1 : upm_model;
    dx = axis_gap(a.min_x, a.max_x, b.min_x, b.max_x);
    dy = axis_gap(a.min_y, a.max_y, b.min_y, b.max_y);
    sum = dx * dx + dy * dy;
    g = int_sqrt(sum);
    if (16 * sum < 9 * upm * upm) begin
      res.is_near = 1'b1;
      res.near_score = closeness(3, upm, g);
    end
    if (16 * sum < upm * upm) begin
      res.is_next_to = 1'b1;
      res.next_to_score = closeness(1, upm, g);
    end
    // footprint inset, all terms scaled by 25
    wx = 5 * (longint'(b.max_x) - longint'(b.min_x));
    wy = 5 * (longint'(b.max_y) - longint'(b.min_y));
    inx = (longint'(upm) < wx) ? longint'(upm) : wx;
    iny = (longint'(upm) < wy) ? longint'(upm) : wy;
    cx = 25 * longint'(a.center_x);
    cy = 25 * longint'(a.center_y);
    hor = cx >= 25 * longint'(b.min_x) + inx && cx <= 25 * longint'(b.max_x) - inx &&
          cy >= 25 * longint'(b.min_y) + iny && cy <= 25 * longint'(b.max_y) - iny;
    vert = a.max_z >= b.min_z && a.min_z <= b.max_z;
    res.is_on = hor && vert;
    res.is_left_of = a.max_x < b.min_x;
    res.is_right_of = a.min_x > b.max_x;
    return res;
  endfunction

  // ---------------- checking ----------------

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    relation_t e;
    if (rst_n && out_valid) begin
      if (pending_relations.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = pending_relations.pop_front();
        if (out_slot_error !== e.slot_error) report("slot_error", out_slot_error, e.slot_error);
        if (out_subject_id !== e.subject_id) report("subject_id", out_subject_id, e.subject_id);
        if (out_reference_id !== e.reference_id)
          report("reference_id", out_reference_id, e.reference_id);
        if (out_is_near !== e.is_near) report("is_near", out_is_near, e.is_near);
        if (out_near_score !== e.near_score) report("near_score", out_near_score, e.near_score);
        if (out_is_next_to !== e.is_next_to) report("is_next_to", out_is_next_to, e.is_next_to);
        if (out_next_to_score !== e.next_to_score)
          report("next_to_score", out_next_to_score, e.next_to_score);
        if (out_is_on !== e.is_on) report("is_on", out_is_on, e.is_on);
        if (out_is_left_of !== e.is_left_of) report("is_left_of", out_is_left_of, e.is_left_of);
        if (out_is_right_of !== e.is_right_of)
          report("is_right_of", out_is_right_of, e.is_right_of);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WD_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------- driving ----------------

  // start is only lowered for a gap, so back-to-back items keep it high
  task automatic send_item(logic req, int s, int r, bpsr_pkg::box_t b);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_slot <= s[3:0];
    in_ref_slot <= r[3:0];
    in_obj_id <= b.id;
    in_min_x <= b.min_x; in_min_y <= b.min_y; in_min_z <= b.min_z;
    in_max_x <= b.max_x; in_max_y <= b.max_y; in_max_z <= b.max_z;
    in_center_x <= b.center_x; in_center_y <= b.center_y;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (req == bpsr_pkg::REQ_QUERY) begin
      pending_relations.insert(pending_relations.size(), predict_relation(s, r));
    end else begin
      box_tab[s] = b;
      slot_used[s] = 1'b1;
    end
  endtask

  function automatic bpsr_pkg::box_t noise_box();
    return bpsr_pkg::box_t'(BOX_BITS'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom}));
  endfunction

  task automatic write_box(int s, bpsr_pkg::box_t b);
    send_item(bpsr_pkg::REQ_WRITE, s, $urandom_range(NSLOT - 1), b);
  endtask

  task automatic query_pair(int s, int r);
    bpsr_pkg::box_t junk;
    junk = noise_box();
    send_item(bpsr_pkg::REQ_QUERY, s, r, junk);
  endtask

  // drain outstanding results, let the core settle, then write the scale
  task automatic set_scale(logic [bpsr_pkg::UPM_W-1:0] v);
    start <= 1'b0;
    while (pending_relations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    upm_model = v;
  endtask

  // ---------------- box generation ----------------

  function automatic int rnd_between(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic signed [bpsr_pkg::COORD_W-1:0] crd(int v);
    return CRD_W'(v);
  endfunction

  function automatic int box_spread();
    int sp;
    sp = (upm_model == 0) ? 1 : int'(upm_model) * 2;
    if (sp < 64) sp = 64;
    if (sp > (1 << 20)) sp = 1 << 20;
    return sp;
  endfunction

  function automatic logic [bpsr_pkg::ID_W-1:0] pick_id();
    // small pool so equal ids come up now and then
    if ($urandom_range(3) == 0) return IDW'($urandom_range(7));
    return IDW'($urandom);
  endfunction

  function automatic bpsr_pkg::box_t shaped_box(int sp);
    bpsr_pkg::box_t b;
    int x0, y0, z0;
    b.id = pick_id();
    x0 = rnd_between(-sp, sp);
    y0 = rnd_between(-sp, sp);
    z0 = rnd_between(-sp, sp);
    b.min_x = crd(x0); b.max_x = crd(x0 + rnd_between(0, sp / 2));
    b.min_y = crd(y0); b.max_y = crd(y0 + rnd_between(0, sp / 2));
    b.min_z = crd(z0); b.max_z = crd(z0 + rnd_between(0, sp / 2));
    b.center_x = crd(rnd_between(b.min_x, b.max_x));
    b.center_y = crd(rnd_between(b.min_y, b.max_y));
    if ($urandom_range(9) == 0) begin
      b.min_x = crd(b.max_x + 1 + rnd_between(0, sp / 4));
    end
    return b;
  endfunction

  // subject placed on, beside or touching a given reference, or left random
  function automatic bpsr_pkg::box_t related_box(bpsr_pkg::box_t rb, int sp);
    bpsr_pkg::box_t b;
    int w, h;
    b = shaped_box(sp);
    w = rnd_between(0, sp / 4);
    h = rnd_between(0, sp / 4);
    case ($urandom_range(3))
      0: begin
        b.center_x = crd(rnd_between(rb.min_x, rb.max_x));
        b.center_y = crd(rnd_between(rb.min_y, rb.max_y));
        b.min_x = crd(b.center_x - w); b.max_x = crd(b.center_x + w);
        b.min_y = crd(b.center_y - h); b.max_y = crd(b.center_y + h);
        b.min_z = crd(rb.max_z - rnd_between(0, 2));
        b.max_z = crd(b.min_z + rnd_between(0, sp / 4));
      end
      1: begin
        b.min_x = crd(rb.max_x + rnd_between(0, sp / 2));
        b.max_x = crd(b.min_x + w);
        b.min_y = crd(rb.min_y + rnd_between(-sp / 4, sp / 4));
        b.max_y = crd(b.min_y + h);
      end
      2: begin
        b.max_x = crd(rb.min_x - rnd_between(0, sp / 3));
        b.min_x = crd(b.max_x - w);
        b.max_y = crd(rb.min_y - rnd_between(0, sp / 3));
        b.min_y = crd(b.max_y - h);
      end
      default: ;
    endcase
    return b;
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed();
    bpsr_pkg::box_t b;
    query_pair(0, 1);                     // both slots unwritten
    b = '{id: 16'h0001, min_x: 0, min_y: 0, min_z: 0, max_x: 4096, max_y: 4096,
          max_z: 4096, center_x: 2048, center_y: 2048};
    write_box(0, b);
    query_pair(0, 1);                     // reference unwritten
    query_pair(1, 0);                     // subject unwritten
    b.id = 16'h0001;
    b.min_x = 8192; b.max_x = 9000;
    write_box(1, b);
    query_pair(0, 1);                     // equal ids
    b = '{id: 16'hFFFF, min_x: -24'sd8388608, min_y: -24'sd8388608, min_z: -24'sd8388608,
          max_x: 24'sd8388607, max_y: 24'sd8388607, max_z: 24'sd8388607,
          center_x: 24'sd8388607, center_y: -24'sd8388608};
    write_box(2, b);
    b = '{id: 16'h0000, min_x: 24'sd8388607, min_y: 24'sd8388607, min_z: 24'sd8388607,
          max_x: -24'sd8388608, max_y: -24'sd8388608, max_z: -24'sd8388608,
          center_x: -24'sd8388608, center_y: 24'sd8388607};
    write_box(3, b);                      // inverted box at the extremes
    query_pair(2, 3);
    query_pair(3, 2);
    query_pair(0, 2);
    // touching boxes, zero gap
    b = '{id: 16'h0010, min_x: 4096, min_y: 0, min_z: 0, max_x: 6000, max_y: 4096,
          max_z: 4096, center_x: 5000, center_y: 100};
    write_box(4, b);
    query_pair(4, 0);
    query_pair(0, 4);
    // small box sitting on slot 0
    b = '{id: 16'h0020, min_x: 1800, min_y: 1800, min_z: 4096, max_x: 2200, max_y: 2200,
          max_z: 6000, center_x: 2048, center_y: 2048};
    write_box(5, b);
    query_pair(5, 0);
    query_pair(0, 5);
    // far to the right, beyond the near distance
    b = '{id: 16'h0030, min_x: 20000, min_y: 0, min_z: 0, max_x: 21000, max_y: 4096,
          max_z: 4096, center_x: 20500, center_y: 2000};
    write_box(6, b);
    query_pair(6, 0);
    query_pair(0, 6);
    query_pair(5, 5);
  endtask

  task automatic test_random(int n, int pct);
    int cnt, s, r;
    idle_pct = pct;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(9))
        0: begin
          write_box($urandom_range(NSLOT - 1), noise_box());
          cnt++;
        end
        1, 2, 3: begin
          write_box($urandom_range(NSLOT - 1), shaped_box(box_spread()));
          cnt++;
        end
        4, 5, 6: begin
          r = $urandom_range(NSLOT - 1);
          s = (r + 1 + $urandom_range(NSLOT - 2)) % NSLOT;
          write_box(r, shaped_box(box_spread()));
          write_box(s, related_box(box_tab[r], box_spread()));
          query_pair(s, r);
          query_pair(r, s);
          cnt += 4;
        end
        default: begin
          query_pair($urandom_range(NSLOT - 1), $urandom_range(NSLOT - 1));
          cnt++;
        end
      endcase
    end
  endtask

  task automatic test_scale_extremes();
    set_scale(20'd1);
    test_random(150, 0);
    set_scale(20'hFFFFF);
    test_random(150, 0);
    set_scale(20'd0);
    test_random(60, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 37;
    test_directed();
    set_scale(bpsr_pkg::UPM_RESET);
    test_random(650, 37);
    set_scale(UPW'($urandom_range(256, 65536)));
    test_random(550, 50);
    test_scale_extremes();
    set_scale(UPW'($urandom_range(1, 20'hFFFFF)));
    test_random(300, 0);
    start <= 1'b0;
    while (pending_relations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
